>>> rtl/avrid_pkg.sv
package avrid_pkg;

  // mnemonic numbers
  localparam logic [6:0] INSTR_NOP       = 7'd0;
  localparam logic [6:0] INSTR_IJMP      = 7'd1;
  localparam logic [6:0] INSTR_EIJMP     = 7'd2;
  localparam logic [6:0] INSTR_RET       = 7'd3;
  localparam logic [6:0] INSTR_ICALL     = 7'd4;
  localparam logic [6:0] INSTR_RETI      = 7'd5;
  localparam logic [6:0] INSTR_EICALL    = 7'd6;
  localparam logic [6:0] INSTR_SLEEP     = 7'd7;
  localparam logic [6:0] INSTR_BREAK     = 7'd8;
  localparam logic [6:0] INSTR_WDR       = 7'd9;
  localparam logic [6:0] INSTR_LPM       = 7'd10;
  localparam logic [6:0] INSTR_ELPM      = 7'd11;
  localparam logic [6:0] INSTR_SPM       = 7'd12;
  localparam logic [6:0] INSTR_MOVW      = 7'd13;
  localparam logic [6:0] INSTR_MULS      = 7'd14;
  localparam logic [6:0] INSTR_MULSU     = 7'd15;
  localparam logic [6:0] INSTR_CPC       = 7'd19;
  localparam logic [6:0] INSTR_MUL       = 7'd30;
  localparam logic [6:0] INSTR_BRBS      = 7'd31;
  localparam logic [6:0] INSTR_BRBC      = 7'd32;
  localparam logic [6:0] INSTR_CPI       = 7'd33;
  localparam logic [6:0] INSTR_RJMP      = 7'd38;
  localparam logic [6:0] INSTR_RCALL     = 7'd39;
  localparam logic [6:0] INSTR_LDI       = 7'd40;
  localparam logic [6:0] INSTR_LDS       = 7'd41;
  localparam logic [6:0] INSTR_LD        = 7'd42;
  localparam logic [6:0] INSTR_POP       = 7'd43;
  localparam logic [6:0] INSTR_STS       = 7'd44;
  localparam logic [6:0] INSTR_ST        = 7'd45;
  localparam logic [6:0] INSTR_PUSH      = 7'd46;
  localparam logic [6:0] INSTR_COM       = 7'd47;
  localparam logic [6:0] INSTR_ASR       = 7'd51;
  localparam logic [6:0] INSTR_DEC       = 7'd54;
  localparam logic [6:0] INSTR_LDD       = 7'd55;
  localparam logic [6:0] INSTR_STD       = 7'd56;
  localparam logic [6:0] INSTR_BSET      = 7'd57;
  localparam logic [6:0] INSTR_BCLR      = 7'd58;
  localparam logic [6:0] INSTR_JMP       = 7'd59;
  localparam logic [6:0] INSTR_CALL      = 7'd60;
  localparam logic [6:0] INSTR_ADIW      = 7'd61;
  localparam logic [6:0] INSTR_SBIW      = 7'd62;
  localparam logic [6:0] INSTR_CBI       = 7'd63;
  localparam logic [6:0] INSTR_IN        = 7'd67;
  localparam logic [6:0] INSTR_OUT       = 7'd68;
  localparam logic [6:0] INSTR_BLD       = 7'd69;
  localparam logic [6:0] INSTR_UNUSED    = 7'd73;
  localparam logic [6:0] INSTR_RESERVED  = 7'd74;
  localparam logic [6:0] INSTR_UNDECODED = 7'd75;

  // pointer select
  localparam logic [1:0] PTR_Z    = 2'd0;
  localparam logic [1:0] PTR_Y    = 2'd1;
  localparam logic [1:0] PTR_X    = 2'd2;
  localparam logic [1:0] PTR_NONE = 2'd3;

  // addressing mode
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_POST  = 2'd1;
  localparam logic [1:0] MODE_PRE   = 2'd2;
  localparam logic [1:0] MODE_DISP  = 2'd3;

  localparam logic [1:0] WORDS_ONE = 2'd1;
  localparam logic [1:0] WORDS_TWO = 2'd2;

  typedef struct packed {
    logic [6:0]  code;
    logic [4:0]  dreg;
    logic [4:0]  sreg;
    logic [21:0] imm;
    logic [11:0] off;
    logic [2:0]  bit_idx;
    logic [5:0]  io;
    logic [1:0]  ptr;
    logic [1:0]  mode;
    logic [1:0]  words;
  } dec_t;

  // pointer and mode of the plain LD/ST forms
  function automatic dec_t ldst_ptr(input dec_t r_in, input logic [15:0] m);
    dec_t r;
    r = r_in;
    case (m[3:2])
      2'b00:   r.ptr = PTR_Z;
      2'b10:   r.ptr = PTR_Y;
      default: r.ptr = PTR_X;
    endcase
    r.mode = m[1:0];
    return r;
  endfunction

  function automatic dec_t decode(input logic [15:0] m, input logic [15:0] w);
    dec_t r;
    logic [3:0] lo;
    logic       exact;
    lo    = m[3:0];
    exact = 1'b1;
    r.code    = INSTR_UNDECODED;
    r.dreg    = '0;
    r.sreg    = '0;
    r.imm     = '0;
    r.off     = '0;
    r.bit_idx = '0;
    r.io      = '0;
    r.ptr     = PTR_NONE;
    r.mode    = MODE_PLAIN;
    r.words   = WORDS_ONE;

    // implied-operand words first
    case (m)
      16'h0000: r.code = INSTR_NOP;
      16'h9409: r.code = INSTR_IJMP;
      16'h9419: r.code = INSTR_EIJMP;
      16'h9508: r.code = INSTR_RET;
      16'h9509: r.code = INSTR_ICALL;
      16'h9518: r.code = INSTR_RETI;
      16'h9519: r.code = INSTR_EICALL;
      16'h9588: r.code = INSTR_SLEEP;
      16'h9598: r.code = INSTR_BREAK;
      16'h95A8: r.code = INSTR_WDR;
      16'h95C8: begin
        r.code = INSTR_LPM;
        r.ptr  = PTR_Z;
      end
      16'h95D8: begin
        r.code = INSTR_ELPM;
        r.ptr  = PTR_Z;
      end
      16'h95E8: begin
        r.code = INSTR_SPM;
        r.ptr  = PTR_Z;
      end
      16'h95F8: begin
        r.code = INSTR_SPM;
        r.ptr  = PTR_Z;
        r.mode = MODE_POST;
      end
      default: exact = 1'b0;
    endcase

    if (exact) begin
      // done
    end else if (m[15:8] == 8'h01) begin
      r.code = INSTR_MOVW;
      r.dreg = {m[7:4], 1'b0};
      r.sreg = {m[3:0], 1'b0};
    end else if (m[15:8] == 8'h02) begin
      r.code = INSTR_MULS;
      r.dreg = {1'b1, m[7:4]};
      r.sreg = {1'b1, m[3:0]};
    end else if (m[15:8] == 8'h03) begin
      r.code = INSTR_MULSU + {5'd0, m[7], m[3]};
      r.dreg = {2'b10, m[6:4]};
      r.sreg = {2'b10, m[2:0]};
    end else if ((m[15:10] >= 6'd1 && m[15:10] <= 6'd11) || m[15:10] == 6'd39) begin
      // two-register alu group
      r.code = (m[15:10] == 6'd39) ? INSTR_MUL : INSTR_CPC + {1'b0, m[15:10]} - 7'd1;
      r.dreg = m[8:4];
      r.sreg = {m[9], m[3:0]};
    end else if (m[15:11] == 5'b11110) begin
      r.code    = m[10] ? INSTR_BRBC : INSTR_BRBS;
      r.off     = {{5{m[9]}}, m[9:3]};
      r.bit_idx = m[2:0];
    end else if (m[15:12] >= 4'd3 && m[15:12] <= 4'd7) begin
      r.code = INSTR_CPI + {3'd0, m[15:12]} - 7'd3;
      r.dreg = {1'b1, m[7:4]};
      r.imm  = {14'd0, m[11:8], m[3:0]};
    end else if (m[15:13] == 3'b110) begin
      r.code = m[12] ? INSTR_RCALL : INSTR_RJMP;
      r.off  = m[11:0];
    end else if (m[15:12] == 4'hE) begin
      r.code = INSTR_LDI;
      r.dreg = {1'b1, m[7:4]};
      r.imm  = {14'd0, m[11:8], m[3:0]};
    end else if (m[15:9] == 7'b1001000) begin
      r.dreg = m[8:4];
      case (lo)
        4'h0: begin
          r.code  = INSTR_LDS;
          r.imm   = {6'd0, w};
          r.words = WORDS_TWO;
        end
        4'h4, 4'h5: begin
          r.code = INSTR_LPM;
          r.ptr  = PTR_Z;
          r.mode = {1'b0, lo[0]};
        end
        4'h6, 4'h7: begin
          r.code = INSTR_ELPM;
          r.ptr  = PTR_Z;
          r.mode = {1'b0, lo[0]};
        end
        4'h3, 4'h8, 4'hB: begin
          r.dreg = '0;
          r.code = INSTR_RESERVED;
        end
        4'hF: r.code = INSTR_POP;
        default: begin
          r.code = INSTR_LD;
          r      = ldst_ptr(r, m);
        end
      endcase
    end else if (m[15:9] == 7'b1001001) begin
      r.sreg = m[8:4];
      case (lo)
        4'h0: begin
          r.code  = INSTR_STS;
          r.imm   = {6'd0, w};
          r.words = WORDS_TWO;
        end
        4'h1, 4'h2, 4'h9, 4'hA, 4'hC, 4'hD, 4'hE: begin
          r.code = INSTR_ST;
          r      = ldst_ptr(r, m);
        end
        4'hF: r.code = INSTR_PUSH;
        default: begin
          r.sreg = '0;
          r.code = INSTR_RESERVED;
        end
      endcase
    end else if (m[15:9] == 7'b1001010 && (lo <= 4'd7 || lo == 4'hA)) begin
      if (lo == 4'd4) begin
        r.code = INSTR_RESERVED;
      end else begin
        r.dreg = m[8:4];
        if (lo == 4'hA) r.code = INSTR_DEC;
        else if (lo <= 4'd3) r.code = INSTR_COM + {3'd0, lo};
        else r.code = INSTR_ASR + {3'd0, lo} - 7'd5;
      end
    end else if (m[15:14] == 2'b10 && !m[12]) begin
      // displacement load/store
      r.imm  = {16'd0, m[13], m[11:10], m[2:0]};
      r.ptr  = m[3] ? PTR_Y : PTR_Z;
      r.mode = MODE_DISP;
      if (!m[9]) begin
        r.code = INSTR_LDD;
        r.dreg = m[8:4];
      end else begin
        r.code = INSTR_STD;
        r.sreg = m[8:4];
      end
    end else if (m[15:8] == 8'h94 && lo == 4'h8) begin
      r.code    = m[7] ? INSTR_BCLR : INSTR_BSET;
      r.bit_idx = m[6:4];
    end else if (m[15:9] == 7'b1001010 && m[3:2] == 2'b11) begin
      r.code  = m[1] ? INSTR_CALL : INSTR_JMP;
      r.imm   = {m[8:4], m[0], w};
      r.words = WORDS_TWO;
    end else if (m[15:9] == 7'b1001011) begin
      r.code = m[8] ? INSTR_SBIW : INSTR_ADIW;
      r.dreg = {2'b11, m[5:4], 1'b0};
      r.imm  = {16'd0, m[7:6], m[3:0]};
    end else if (m[15:10] == 6'b100110) begin
      r.code    = INSTR_CBI + {5'd0, m[9:8]};
      r.io      = {1'b0, m[7:3]};
      r.bit_idx = m[2:0];
    end else if (m[15:12] == 4'hB) begin
      r.io = {m[10:9], m[3:0]};
      if (!m[11]) begin
        r.code = INSTR_IN;
        r.dreg = m[8:4];
      end else begin
        r.code = INSTR_OUT;
        r.sreg = m[8:4];
      end
    end else if (m[15:11] == 5'b11111) begin
      r.code    = INSTR_BLD + {5'd0, m[10:9]};
      r.dreg    = m[8:4];
      r.bit_idx = m[2:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/avr_instruction_decoder.sv
// avr instruction decoder
// slave stream: one transfer per instruction; tdata carries the opcode word
// and the word after it (only lds, sts, jmp and call look at the second word)
// master stream: one transfer per instruction; tuser carries the mnemonic
// number and tdata the operand fields
// path: an accepted instruction goes through the input register, the
// decode and the result register before tvalid rises on the master side
// throughput: one instruction per cycle while the master side keeps tready
// high, set by the single-pass decode between the two registers; both
// registers advance in the same cycle when the master side takes its result
// stall: while the receiver holds tready low, the result stays put and the
// input register still takes one more instruction; tready on the slave
// side then drops until the result register drains
// reset: both valid flags clear, no result is pending after reset
// undecodable words give mnemonic 75 and reserved ones 74, with all
// operand fields at their unused values (pointer 3, one word)
module avr_instruction_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] opcode_word, [31:16] extension_word
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] dest_reg, [9:5] src_reg, [31:10] immediate, [43:32] branch_offset,
  // [46:44] bit_index, [52:47] io_addr, [54:53] pointer_sel,
  // [56:55] addr_mode, [58:57] words_used, [63:59] zero
  output logic [63:0] m_axis_tdata,
  // [6:0] instr_code
  output logic [6:0]  m_axis_tuser
);
  import avrid_pkg::*;

  logic        in_valid_q;
  logic [15:0] opcode_q;
  logic [15:0] ext_q;
  logic        out_valid_q;
  dec_t        res_q;
  dec_t        res_d;
  logic        out_ready;
  logic        s_xfer;
  logic        adv;

  // result register frees when empty or taken this cycle
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign adv           = in_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (out_ready) out_valid_q <= in_valid_q;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      opcode_q <= s_axis_tdata[15:0];
      ext_q    <= s_axis_tdata[31:16];
    end
  end

  // single-pass decode
  assign res_d = decode(opcode_q, ext_q);

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.code;
  assign m_axis_tdata  = {5'd0, res_q.words, res_q.mode, res_q.ptr, res_q.io,
                          res_q.bit_idx, res_q.off, res_q.imm, res_q.sreg,
                          res_q.dreg};

`ifndef SYNTHESIS
  // an accepted instruction is held in the input register next cycle
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> in_valid_q)
    else $error("accepted instruction not held in input register");

  // a decoded instruction moves into the result register
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("decoded instruction lost on its way to the result register");

  // only the four two-word instructions report two words
  a_two_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.words == WORDS_TWO) |->
      (res_q.code == INSTR_LDS || res_q.code == INSTR_STS ||
       res_q.code == INSTR_JMP || res_q.code == INSTR_CALL))
    else $error("two-word result on a one-word instruction");

  // mnemonic stays in range and skips the unused number
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.code <= INSTR_UNDECODED && res_q.code != INSTR_UNUSED))
    else $error("mnemonic number out of range");

  // a pointer is reported only by the memory access forms
  a_pointer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.ptr != PTR_NONE) |->
      (res_q.code == INSTR_LPM || res_q.code == INSTR_ELPM ||
       res_q.code == INSTR_SPM || res_q.code == INSTR_LD ||
       res_q.code == INSTR_ST || res_q.code == INSTR_LDD ||
       res_q.code == INSTR_STD))
    else $error("pointer reported on a non-memory instruction");
`endif

endmodule
